>>> hw/rtl/sac_pkg.sv
// Types, constants and coil tables shared by the stepper axis angle controller.
package sac_pkg;

  localparam int ANGLE_BITS      = 9;
  localparam int STEP_COUNT_BITS = 13;

  localparam int TARGET_BITS     = 9;
  localparam int SPR_BITS        = 13;
  localparam int MAX_ANGLE_BITS  = 9;
  localparam int COIL_BITS       = 4;
  localparam int STEPS_LEFT_BITS = 13;
  localparam int PHASE_BITS      = 2;

  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 13;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEPS_PER_REV = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ANGLE     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIVE_PATTERN = 2'd2;

  localparam logic [SPR_BITS-1:0]       SPR_RESET       = SPR_BITS'(400);
  localparam logic [MAX_ANGLE_BITS-1:0] MAX_ANGLE_RESET = MAX_ANGLE_BITS'(360);

  localparam logic FUNC_SET_TARGET = 1'b0;
  localparam logic FUNC_TICK       = 1'b1;

  localparam logic PATTERN_FULL_STEP = 1'b0;
  localparam logic PATTERN_WAVE      = 1'b1;

  // Step count: floor(diff * steps_per_rev / 360) = floor((product >> 3) / 45)
  localparam int DEG_PER_REV   = 360;
  localparam int ODD_DIVISOR   = DEG_PER_REV / 8;
  localparam int PROD_BITS     = ANGLE_BITS + SPR_BITS;
  localparam int Y_BITS        = PROD_BITS - 3;
  localparam int RECIP_SHIFT   = Y_BITS + 6;
  localparam int RECIP_BITS    = RECIP_SHIFT - 5;
  localparam int WIDE_BITS     = Y_BITS + RECIP_BITS;
  localparam int QUOT_BITS     = PROD_BITS - 8;
  localparam int CMP_BITS      = (QUOT_BITS > STEP_COUNT_BITS) ? QUOT_BITS : STEP_COUNT_BITS;
  localparam longint unsigned RECIP_VALUE =
    ((longint'(1) << RECIP_SHIFT) + longint'(ODD_DIVISOR - 1)) / longint'(ODD_DIVISOR);
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VALUE);

  localparam logic [COIL_BITS-1:0] FULL_STEP_TABLE [4] = '{4'h5, 4'h6, 4'hA, 4'h9};
  localparam logic [COIL_BITS-1:0] WAVE_TABLE      [4] = '{4'h1, 4'h2, 4'h4, 4'h8};

  typedef struct packed {
    logic                   func;
    logic [TARGET_BITS-1:0] target_angle;
    logic                   home_sensed;
  } sac_cmd_t;

  typedef struct packed {
    logic [COIL_BITS-1:0]       coil_drive;
    logic                       stepped;
    logic [STEPS_LEFT_BITS-1:0] steps_left;
    logic                       turning_clockwise;
  } sac_res_t;

endpackage

>>> hw/rtl/stepper_axis_angle_controller.sv
// Stepper axis angle controller: target-to-step conversion and coil phase sequencing.
// An input register and a result register part the channels; each item passes both in turn.
// Throughput: one item per cycle while the result register is not stalled by res_ready.
// Each item does one multiply and one reciprocal constant divide between the two registers.
// Reset (rst, synchronous): registers to their reset values, no pending steps, coils off,
// clockwise, homing disarmed, both stages empty.
module stepper_axis_angle_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  sac_pkg::sac_cmd_t                   cmd,
  output logic                                res_valid,
  input  logic                                res_ready,
  output sac_pkg::sac_res_t                   res,
  input  logic                                cfg_we,
  input  logic [sac_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sac_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic [sac_pkg::SPR_BITS-1:0]        steps_per_rev;
  logic [sac_pkg::MAX_ANGLE_BITS-1:0]  max_angle;
  logic                                drive_pattern;

  logic [sac_pkg::STEP_COUNT_BITS-1:0] remaining_steps;
  logic [sac_pkg::ANGLE_BITS-1:0]      current_angle;
  logic                                clockwise;
  logic                                home_armed;
  logic [sac_pkg::PHASE_BITS-1:0]      phase;
  logic [sac_pkg::COIL_BITS-1:0]       coil_latch;

  logic [sac_pkg::STEP_COUNT_BITS-1:0] remaining_steps_next;
  logic [sac_pkg::ANGLE_BITS-1:0]      current_angle_next;
  logic                                clockwise_next;
  logic                                home_armed_next;
  logic [sac_pkg::PHASE_BITS-1:0]      phase_next;
  logic [sac_pkg::COIL_BITS-1:0]       coil_latch_next;
  logic                                stepped_next;

  logic                                s1_valid;
  sac_pkg::sac_cmd_t                   s1;
  logic                                advance;

  logic [sac_pkg::ANGLE_BITS-1:0]      target;
  logic [sac_pkg::ANGLE_BITS-1:0]      diff;
  logic                                set_clockwise;
  logic [sac_pkg::PROD_BITS-1:0]       product;
  logic [sac_pkg::Y_BITS-1:0]          product_div8;
  logic [sac_pkg::WIDE_BITS-1:0]       recip_product;
  logic [sac_pkg::QUOT_BITS-1:0]       quotient;
  logic [sac_pkg::STEP_COUNT_BITS-1:0] step_count;
  logic [sac_pkg::PHASE_BITS-1:0]      row;

  assign advance   = s1_valid && (!res_valid || res_ready);
  assign cmd_ready = !s1_valid || advance;

  // Step count for a set-angle item
  always_comb begin
    target = sac_pkg::ANGLE_BITS'(s1.target_angle);
    if (current_angle < target) begin
      diff          = target - current_angle;
      set_clockwise = 1'b0;
    end else begin
      diff          = current_angle - target;
      set_clockwise = 1'b1;
    end
    product       = sac_pkg::PROD_BITS'(diff) * sac_pkg::PROD_BITS'(steps_per_rev);
    product_div8  = product[sac_pkg::PROD_BITS-1:3];
    recip_product = sac_pkg::WIDE_BITS'(product_div8) * sac_pkg::WIDE_BITS'(sac_pkg::RECIP);
    quotient      = sac_pkg::QUOT_BITS'(recip_product >> sac_pkg::RECIP_SHIFT);
    if (sac_pkg::CMP_BITS'(quotient) >
        sac_pkg::CMP_BITS'({sac_pkg::STEP_COUNT_BITS{1'b1}})) begin
      step_count = '1;
    end else begin
      step_count = sac_pkg::STEP_COUNT_BITS'(quotient);
    end
  end

  // Next state for the item in the input register
  always_comb begin
    remaining_steps_next = remaining_steps;
    current_angle_next   = current_angle;
    clockwise_next       = clockwise;
    home_armed_next      = home_armed;
    phase_next           = phase;
    coil_latch_next      = coil_latch;
    stepped_next         = 1'b0;
    row                  = phase;
    case (s1.func)
      sac_pkg::FUNC_SET_TARGET: begin
        if (s1.target_angle == '0) begin
          home_armed_next = 1'b1;
        end
        if (s1.target_angle <= max_angle) begin
          clockwise_next       = set_clockwise;
          remaining_steps_next = step_count;
          current_angle_next   = target;
        end
      end
      sac_pkg::FUNC_TICK: begin
        if (remaining_steps != '0) begin
          remaining_steps_next = remaining_steps - 1'b1;
          phase_next           = phase + 1'b1;
          row                  = clockwise ? phase_next : 2'(2'd0 - phase_next);
          coil_latch_next      = (drive_pattern == sac_pkg::PATTERN_WAVE) ?
                                 sac_pkg::WAVE_TABLE[row] : sac_pkg::FULL_STEP_TABLE[row];
          stepped_next         = 1'b1;
        end
        if (s1.home_sensed && home_armed) begin
          remaining_steps_next = '0;
          home_armed_next      = 1'b0;
        end
      end
      default: begin
        remaining_steps_next = remaining_steps;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_rev <= sac_pkg::SPR_RESET;
      max_angle     <= sac_pkg::MAX_ANGLE_RESET;
      drive_pattern <= sac_pkg::PATTERN_FULL_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        sac_pkg::CFG_STEPS_PER_REV: steps_per_rev <= cfg_data[sac_pkg::SPR_BITS-1:0];
        sac_pkg::CFG_MAX_ANGLE:     max_angle     <= cfg_data[sac_pkg::MAX_ANGLE_BITS-1:0];
        sac_pkg::CFG_DRIVE_PATTERN: drive_pattern <= cfg_data[0];
        default:                    drive_pattern <= drive_pattern;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      res_valid       <= 1'b0;
      remaining_steps <= '0;
      current_angle   <= '0;
      clockwise       <= 1'b1;
      home_armed      <= 1'b0;
      phase           <= '0;
      coil_latch      <= '0;
    end else begin
      if (cmd_ready) begin
        s1_valid <= cmd_valid;
      end
      if (advance) begin
        res_valid       <= 1'b1;
        remaining_steps <= remaining_steps_next;
        current_angle   <= current_angle_next;
        clockwise       <= clockwise_next;
        home_armed      <= home_armed_next;
        phase           <= phase_next;
        coil_latch      <= coil_latch_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      s1 <= cmd;
    end
    if (advance) begin
      res.coil_drive        <= coil_latch_next;
      res.stepped           <= stepped_next;
      res.steps_left        <= sac_pkg::STEPS_LEFT_BITS'(remaining_steps_next);
      res.turning_clockwise <= clockwise_next;
    end
  end

`ifndef SYNTH
  a_step_drives_coils: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.stepped |-> res.coil_drive != '0)
    else $error("step reported with all coils off");

  a_tick_counts_down: assert property (@(posedge clk) disable iff (rst)
    advance && s1.func == sac_pkg::FUNC_TICK && remaining_steps != '0 &&
    !(s1.home_sensed && home_armed)
    |=> remaining_steps == $past(remaining_steps) - 1'b1)
    else $error("tick did not spend exactly one step");

  a_home_clears: assert property (@(posedge clk) disable iff (rst)
    advance && s1.func == sac_pkg::FUNC_TICK && s1.home_sensed && home_armed
    |=> remaining_steps == '0 && !home_armed)
    else $error("home not honoured while armed");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1))
    else $error("stalled item lost from input register");
`endif

endmodule
